// ===== rtl/cfq_pkg.sv =====
`timescale 1ns / 1ps

package cfq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   // Front queue geometry
   localparam int FRONT_DEPTH  = 2;
   localparam int FRONT_IDX_W  = $clog2(FRONT_DEPTH);
   localparam int FRONT_FILL_W = $clog2(FRONT_DEPTH + 1);

   // Field widths
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 29;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 16;

   // Stream bus widths
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 152;
   localparam int RSP_USER_W = STATUS_W + 1;
   localparam int RSP_PAD_W  = RSP_DATA_W - (ID_W + LEN_W + DATA_W + TIME_W + COUNT_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_FIND = 2'd2
   } cfq_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_FRAME   = 2'd0,
      STAT_STORED  = 2'd1,
      STAT_DROPPED = 2'd2,
      STAT_EMPTY   = 2'd3
   } cfq_status_type;

   // One stored frame
   typedef struct packed {
      logic              ext;
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] payload;
      logic [TIME_W-1:0] stamp;
   } cfq_frame_type;

   // Classified command passed from front to back
   typedef struct packed {
      cfq_cmd_type   cmd;
      cfq_frame_type frame;
   } cfq_item_type;

   // Result handed to the output stream
   typedef struct packed {
      cfq_status_type     status;
      cfq_frame_type      frame;
      logic [COUNT_W-1:0] total;
   } cfq_rsp_type;

   localparam int FRAME_W = $bits(cfq_frame_type);

   // Ring pointer advance
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/cfq_ram.sv =====
`timescale 1ns / 1ps

module cfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/cfq_front.sv =====
`timescale 1ns / 1ps

module cfq_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cfq_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [cfq_pkg::CMD_W-1:0]         req_tuser,
   output logic                              item_valid,
   input  logic                              item_ready,
   output cfq_pkg::cfq_item_type             item_data
);

   import cfq_pkg::*;

   logic [7:0]   sid_high;
   logic [7:0]   sid_low;
   logic [7:0]   eid_high;
   logic [7:0]   eid_low;
   logic [7:0]   dlc_raw;
   cfq_item_type item_new;

   cfq_item_type            q_ff [FRONT_DEPTH];
   logic [FRONT_IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [FRONT_IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [FRONT_FILL_W-1:0] fill_ff, fill_in;
   logic                    push;
   logic                    pop;

   // Unpack the raw register bytes
   assign sid_high = req_tdata[7:0];
   assign sid_low  = req_tdata[15:8];
   assign eid_high = req_tdata[23:16];
   assign eid_low  = req_tdata[31:24];
   assign dlc_raw  = req_tdata[39:32];

   // Classify the item and assemble the identifier
   always_comb begin
      item_new.cmd           = cfq_cmd_type'(req_tuser);
      item_new.frame.ext     = sid_low[3];
      if (sid_low[3]) begin
         item_new.frame.id = {sid_high, sid_low[7:5], sid_low[1:0], eid_high, eid_low};
      end else begin
         item_new.frame.id = {18'd0, sid_high, sid_low[7:5]};
      end
      item_new.frame.len     = dlc_raw[LEN_W-1:0];
      item_new.frame.payload = req_tdata[103:40];
      item_new.frame.stamp   = req_tdata[135:104];
   end

   // Small queue toward the back part
   assign req_tready = (fill_ff != FRONT_FILL_W'(FRONT_DEPTH));
   assign item_valid = (fill_ff != '0);
   assign item_data  = q_ff[rd_idx_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_idx_in = push ? wr_idx_ff + FRONT_IDX_W'(1) : wr_idx_ff;
      rd_idx_in = pop ? rd_idx_ff + FRONT_IDX_W'(1) : rd_idx_ff;
      fill_in   = fill_ff + FRONT_FILL_W'(push) - FRONT_FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold the entry payloads
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_idx_ff] <= item_new;
      end
   end

endmodule

// ===== rtl/cfq_back.sv =====
`timescale 1ns / 1ps

module cfq_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   output logic                       item_ready,
   input  cfq_pkg::cfq_item_type      item_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [cfq_pkg::ID_W-1:0]   csr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cfq_pkg::cfq_rsp_type       rsp_data
);

   import cfq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_FIND
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [COUNT_W-1:0] store_count_ff, store_count_in;
   logic [ID_W-1:0]    target_ff, target_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cfq_rsp_type        rsp_ff, rsp_in;

   logic               out_free;
   logic               emit;
   logic [PTR_W-1:0]   rptr_next;
   logic [PTR_W-1:0]   wptr_next;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [FRAME_W-1:0] ram_rd_data;
   cfq_frame_type      rd_frame;

   cfq_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (wptr_ff),
      .wr_data    (item_data.frame),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   assign rd_frame   = cfq_frame_type'(ram_rd_data);
   assign rptr_next  = next_slot(rptr_ff);
   assign wptr_next  = next_slot(wptr_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign item_ready = (state_ff == ST_IDLE) && out_free;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign target_in  = csr_valid ? csr_data : target_ff;

   // Sequence commands over the frame store
   always_comb begin
      state_in       = state_ff;
      wptr_in        = wptr_ff;
      rptr_in        = rptr_ff;
      store_count_in = store_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      emit           = 1'b0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rptr_ff;
      rsp_in.frame   = rsp_ff.frame;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && item_ready) begin
               unique case (item_data.cmd) inside
                  CMD_PUSH: begin
                     emit         = 1'b1;
                     rsp_in.frame = '0;
                     if (wptr_next == rptr_ff) begin
                        rsp_in.status = STAT_DROPPED;
                     end else begin
                        ram_wr_en      = 1'b1;
                        wptr_in        = wptr_next;
                        store_count_in = store_count_ff + COUNT_W'(1);
                        rsp_in.status  = STAT_STORED;
                     end
                  end
                  CMD_POP, CMD_FIND: begin
                     if (rptr_ff == wptr_ff) begin
                        emit          = 1'b1;
                        rsp_in.frame  = '0;
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = (item_data.cmd == CMD_POP) ? ST_POP : ST_FIND;
                     end
                  end
                  default: begin
                     emit          = 1'b1;
                     rsp_in.frame  = '0;
                     rsp_in.status = STAT_EMPTY;
                  end
               endcase
            end
         end
         ST_POP: begin
            emit          = 1'b1;
            rsp_in.frame  = rd_frame;
            rsp_in.status = STAT_FRAME;
            rptr_in       = rptr_next;
            state_in      = ST_IDLE;
         end
         ST_FIND: begin
            rptr_in = rptr_next;
            if (rd_frame.id == target_ff) begin
               emit          = 1'b1;
               rsp_in.frame  = rd_frame;
               rsp_in.status = STAT_FRAME;
               state_in      = ST_IDLE;
            end else if (rptr_next == wptr_ff) begin
               emit          = 1'b1;
               rsp_in.frame  = '0;
               rsp_in.status = STAT_EMPTY;
               state_in      = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rptr_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.total = store_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wptr_ff        <= '0;
         rptr_ff        <= '0;
         store_count_ff <= '0;
         target_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wptr_ff        <= wptr_in;
         rptr_ff        <= rptr_in;
         store_count_ff <= store_count_in;
         target_ff      <= target_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // No result may wait while a read is in flight
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during store read");

   // A read walk only runs over a nonempty queue
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (rptr_ff != wptr_ff))
      else $error("store read on empty queue");

   // Every stored frame bumps the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wptr_ff != $past(wptr_ff)) |->
         (store_count_ff == $past(store_count_ff) + COUNT_W'(1)))
      else $error("frame count out of step with write pointer");

endmodule

// ===== rtl/can_rx_frame_queue_with_id_filter_unit.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake                | Contents
// req     | in        | req_tvalid / req_tready  | command in tuser, raw frame bytes in tdata
// rsp     | out       | rsp_tvalid / rsp_tready  | status and extended flag in tuser, frame in tdata
// csr     | in        | csr_valid / csr_ready    | target identifier for the find command
//
// In the back part a push completes from idle, a pop reads the frame store and then returns
// the frame, and a find examines up to QUEUE_DEPTH - 1 frames; the single read port of the
// frame store examines one frame per cycle. The front queue registers each item.
// Reset is synchronous and leaves the queue empty; the frame store needs no clearing.
// A stalled rsp channel holds the back part, while the front keeps taking up to two items.

module can_rx_frame_queue_with_id_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sid_high, sid_low, eid_high, eid_low, dlc_raw, payload_in, tick_in
   input  logic [cfq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic [cfq_pkg::CMD_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // frame_id, frame_len, payload_out, frame_time, received_total, zero fill
   output logic [cfq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status, is_extended
   output logic [cfq_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cfq_pkg::ID_W-1:0]          csr_data
);

   import cfq_pkg::*;

   logic         item_valid;
   logic         item_ready;
   cfq_item_type item_data;
   cfq_rsp_type  rsp_data;

   cfq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item_data  (item_data)
   );

   cfq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item_data  (item_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_data)
   );

   // Pack the result onto the stream bus
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_data.total, rsp_data.frame.stamp,
                       rsp_data.frame.payload, rsp_data.frame.len, rsp_data.frame.id};
   assign rsp_tuser = {rsp_data.frame.ext, rsp_data.status};

endmodule
